// ===== rtl/lts_pkg.sv =====
`default_nettype none
package lts_pkg;

  localparam int KEY_W   = 64;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 4;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
    logic             cacheable;
  } lts_in_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              replaced;
  } lts_out_t;

  typedef struct packed {
    logic key_we;
    logic stamp_we;
  } lts_wr_ctl_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic fill;
  } lts_cmp_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lts_store.sv =====
`default_nettype none
module lts_store import lts_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64,
  parameter int IDX_W    = $clog2(ENTRIES)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [IDX_W-1:0]    rd_addr,
  input  wire lts_wr_ctl_t         wr_ctl,
  input  wire logic [IDX_W-1:0]    wr_addr,
  input  wire logic [KEY_BITS-1:0] wr_key,
  input  wire logic [STAMP_W-1:0]  wr_stamp,
  output logic [KEY_BITS-1:0]      rd_key_r,
  output logic [STAMP_W-1:0]       rd_stamp_r,
  output logic                     rd_valid_r
);

  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [STAMP_W-1:0]  stamp_mem [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;

  always_ff @(posedge clk) begin
    if (wr_ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_ctl.stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    rd_key_r   <= key_mem[rd_addr];
    rd_stamp_r <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_ctl.key_we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lts_cmp.sv =====
`default_nettype none
module lts_cmp import lts_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64,
  parameter int IDX_W    = $clog2(ENTRIES)
) (
  input  wire logic                clk,
  input  wire lts_cmp_ctl_t        ctl,
  input  wire logic [IDX_W-1:0]    idx,
  input  wire logic [KEY_BITS-1:0] key_q,
  input  wire logic [KEY_BITS-1:0] rd_key,
  input  wire logic [STAMP_W-1:0]  rd_stamp,
  input  wire logic                rd_valid,
  output logic                     found,
  output logic [IDX_W-1:0]         victim_idx
);

  logic [STAMP_W-1:0] best_stamp_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               take;

  // lookup: valid entry with equal key; fill: empty entry
  assign found      = ctl.fill ? !rd_valid : (rd_valid && (rd_key == key_q));
  assign take       = ctl.first || (rd_stamp < best_stamp_r);
  assign victim_idx = take ? idx : best_idx_r;

  always_ff @(posedge clk) begin
    if (ctl.vld && take) begin
      best_stamp_r <= rd_stamp;
      best_idx_r   <= idx;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lru_tag_store_unit.sv =====
// channel | ports                         | handshake
// input   | start, busy, in_item          | taken when start && !busy
// result  | out_strobe, out_item          | one cycle per item, no back-pressure
//
// a lookup or cacheable fill scans the entries one per cycle through one
// store read port and one shared compare unit, and stays busy until the
// scan ends and its result is registered
// a fill that is not cacheable is answered the cycle after it is taken
// synchronous active-low reset empties all entries and clears the time
// the result strobe lasts one cycle; the receiver cannot stall it
`default_nettype none
module lru_tag_store_unit import lts_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire lts_in_t in_item,
  output logic         out_strobe,
  output lts_out_t     out_item
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t              state_r, state_nxt;
  logic                fill_r, fill_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                rd_on_r, rd_on_nxt;
  logic                dv_r, dv_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [STAMP_W-1:0]  now_r, now_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  lts_out_t            out_item_r, out_item_nxt;

  lts_wr_ctl_t         wr_ctl;
  logic [IDX_W-1:0]    wr_addr;
  lts_cmp_ctl_t        cmp_ctl;
  logic [KEY_BITS-1:0] rd_key;
  logic [STAMP_W-1:0]  rd_stamp;
  logic                rd_valid;
  logic                found;
  logic [IDX_W-1:0]    victim_idx;

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  assign cmp_ctl.vld   = dv_r;
  assign cmp_ctl.first = dv_r && (cmp_idx_r == '0);
  assign cmp_ctl.fill  = fill_r;

  lts_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (rd_idx_r),
    .wr_ctl     (wr_ctl),
    .wr_addr    (wr_addr),
    .wr_key     (key_r),
    .wr_stamp   (now_r),
    .rd_key_r   (rd_key),
    .rd_stamp_r (rd_stamp),
    .rd_valid_r (rd_valid)
  );

  lts_cmp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W)
  ) u_cmp (
    .clk        (clk),
    .ctl        (cmp_ctl),
    .idx        (cmp_idx_r),
    .key_q      (key_r),
    .rd_key     (rd_key),
    .rd_stamp   (rd_stamp),
    .rd_valid   (rd_valid),
    .found      (found),
    .victim_idx (victim_idx)
  );

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    key_nxt        = key_r;
    rd_idx_nxt     = rd_idx_r;
    rd_on_nxt      = rd_on_r;
    dv_nxt         = dv_r;
    cmp_idx_nxt    = cmp_idx_r;
    now_nxt        = now_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    wr_ctl         = '0;
    wr_addr        = cmp_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          fill_nxt = (in_item.operation == OP_FILL);
          key_nxt  = in_item.key[KEY_BITS-1:0];
          if ((in_item.operation == OP_FILL) && !in_item.cacheable) begin
            now_nxt        = now_r + 1'b1;
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '0;
          end else begin
            state_nxt  = ST_SCAN;
            rd_idx_nxt = '0;
            rd_on_nxt  = 1'b1;
            dv_nxt     = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        dv_nxt      = rd_on_r;
        cmp_idx_nxt = rd_idx_r;
        if (rd_on_r) begin
          if (rd_idx_r == LAST) begin
            rd_on_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (dv_r) begin
          if (fill_r) begin
            if (found || (cmp_idx_r == LAST)) begin
              wr_ctl.key_we         = 1'b1;
              wr_ctl.stamp_we       = 1'b1;
              wr_addr               = found ? cmp_idx_r : victim_idx;
              now_nxt               = now_r + 1'b1;
              out_strobe_nxt        = 1'b1;
              out_item_nxt.hit      = 1'b0;
              out_item_nxt.slot     = SLOT_W'(wr_addr);
              out_item_nxt.replaced = !found;
              state_nxt             = ST_IDLE;
              rd_on_nxt             = 1'b0;
              dv_nxt                = 1'b0;
            end
          end else begin
            if (found) begin
              wr_ctl.stamp_we       = 1'b1;
              now_nxt               = now_r + 1'b1;
              out_strobe_nxt        = 1'b1;
              out_item_nxt.hit      = 1'b1;
              out_item_nxt.slot     = SLOT_W'(cmp_idx_r);
              out_item_nxt.replaced = 1'b0;
              state_nxt             = ST_IDLE;
              rd_on_nxt             = 1'b0;
              dv_nxt                = 1'b0;
            end else if (cmp_idx_r == LAST) begin
              out_strobe_nxt = 1'b1;
              out_item_nxt   = '0;
              state_nxt      = ST_IDLE;
              rd_on_nxt      = 1'b0;
              dv_nxt         = 1'b0;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_on_r      <= 1'b0;
      dv_r         <= 1'b0;
      now_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_on_r      <= rd_on_nxt;
      dv_r         <= dv_nxt;
      now_r        <= now_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    fill_r     <= fill_nxt;
    key_r      <= key_nxt;
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import lts_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int ITEM_TARGET = 400;
  localparam int CYCLE_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  lts_in_t  in_item = '0;
  logic     out_strobe;
  lts_out_t out_item;

  lru_tag_store_unit #(
    .ENTRIES(ENTRIES),
    .KEY_BITS(KEY_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_strobe(out_strobe),
    .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the tag store
  logic             shadow_valid [ENTRIES];
  logic [KEY_W-1:0] shadow_key   [ENTRIES];
  logic [31:0]      shadow_stamp [ENTRIES];
  logic [31:0]      shadow_now;

  lts_out_t tag_answers_q[$];

  int  items_sent;
  int  lookups;
  int  hits;
  int  fills;
  int  evictions;
  int  uncached;
  int  mismatches;
  int  cycle_count;
  bit  idle_on = 1'b1;

  function automatic lts_out_t tag_lookup_fill(lts_in_t it);
    lts_out_t r;
    bit       found;
    bit       full;
    int       victim;
    r = '0;
    found = 1'b0;
    full = 1'b1;
    victim = 0;
    if (it.operation == OP_LOOKUP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && shadow_valid[i] && shadow_key[i] == it.key) begin
          found = 1'b1;
          shadow_stamp[i] = shadow_now;
          shadow_now = shadow_now + 32'd1;
          r.hit = 1'b1;
          r.slot = SLOT_W'(i);
        end
      end
    end else if (it.cacheable) begin
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (!shadow_valid[i]) begin
          full = 1'b0;
          victim = i;
        end
      end
      if (full) begin
        for (int i = 1; i < ENTRIES; i++) begin
          if (shadow_stamp[i] < shadow_stamp[victim]) victim = i;
        end
      end
      shadow_valid[victim] = 1'b1;
      shadow_key[victim] = it.key;
      shadow_stamp[victim] = shadow_now;
      shadow_now = shadow_now + 32'd1;
      r.slot = SLOT_W'(victim);
      r.replaced = full;
    end else begin
      shadow_now = shadow_now + 32'd1;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input lts_in_t it, output lts_out_t ans);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    ans = tag_lookup_fill(it);
    tag_answers_q.push_back(ans);
    items_sent++;
    if (it.operation == OP_LOOKUP) begin
      lookups++;
      if (ans.hit) hits++;
    end else begin
      fills++;
      if (!it.cacheable) uncached++;
      if (ans.replaced) evictions++;
    end
  endtask

  task automatic send_op(input logic op, input logic [KEY_W-1:0] key, input logic cacheable);
    lts_in_t  it;
    lts_out_t ans;
    it.operation = op;
    it.key = key;
    it.cacheable = cacheable;
    send_item(it, ans);
  endtask

  task automatic do_reset();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_stamp[i] = '0;
    end
    shadow_now = '0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // lookups and fills on an empty store
  task automatic test_empty_store();
    send_op(OP_LOOKUP, '0, 1'b1);
    send_op(OP_FILL, '1, 1'b0);
    send_op(OP_LOOKUP, '1, 1'b0);
  endtask

  // extreme keys, duplicate fill, lowest-index match
  task automatic test_fill_and_hit();
    send_op(OP_FILL, '0, 1'b1);
    send_op(OP_FILL, '1, 1'b1);
    send_op(OP_FILL, '0, 1'b1);
    send_op(OP_LOOKUP, '0, 1'b0);
    send_op(OP_LOOKUP, '1, 1'b1);
  endtask

  // fill the store, then evict the oldest entry
  task automatic test_eviction();
    for (int i = 3; i < ENTRIES; i++) begin
      send_op(OP_FILL, {32'hA5A5_0000 + 32'(i), 32'h0F0F_F0F0 ^ 32'(i)}, 1'b1);
    end
    send_op(OP_FILL, {KEY_W/2{2'b10}}, 1'b1);
    send_op(OP_LOOKUP, {KEY_W/2{2'b01}}, 1'b1);
  endtask

  // lookup then fill on miss, plus lone fills and lookups, over a key pool larger than the store
  task automatic test_random_traffic();
    logic [KEY_W-1:0] pool [24];
    logic [KEY_W-1:0] key;
    lts_in_t          it;
    lts_out_t         ans;
    int               r;
    int               n;
    for (int i = 0; i < 24; i++) pool[i] = rand_key();
    n = 0;
    while (items_sent < ITEM_TARGET + 25) begin
      if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      n++;
      if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, 23)] = rand_key();
      r = $urandom_range(0, 99);
      key = (r < 90) ? pool[$urandom_range(0, 23)] : rand_key();
      if (r < 85) begin
        it.operation = OP_LOOKUP;
        it.key = key;
        it.cacheable = 1'($urandom_range(0, 1));
        send_item(it, ans);
        if (!ans.hit) begin
          it.operation = OP_FILL;
          it.cacheable = ($urandom_range(0, 9) != 0);
          send_item(it, ans);
        end
      end else begin
        it.operation = (r < 93) ? OP_FILL : OP_LOOKUP;
        it.key = key;
        it.cacheable = 1'($urandom_range(0, 1));
        send_item(it, ans);
      end
    end
  endtask

  always @(posedge clk) begin
    lts_out_t want;
    if (rst_n && out_strobe) begin
      if (tag_answers_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0b slot=%0d replaced=%0b",
                   out_item.hit, out_item.slot, out_item.replaced);
      end else begin
        want = tag_answers_q.pop_front();
        if (out_item.hit !== want.hit || out_item.slot !== want.slot ||
            out_item.replaced !== want.replaced) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected hit=%0b slot=%0d replaced=%0b",
                     want.hit, want.slot, want.replaced);
            $display("          got      hit=%0b slot=%0d replaced=%0b",
                     out_item.hit, out_item.slot, out_item.replaced);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    do_reset();
    test_empty_store();
    test_fill_and_hit();
    test_eviction();
    test_random_traffic();
    start <= 1'b0;
    while (tag_answers_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
    if (tag_answers_q.size() != 0) mismatches++;
    $display("%0d items: %0d lookups with %0d hits, %0d fills", items_sent, lookups, hits, fills);
    $display("%0d fills evicted the oldest entry, %0d were not cacheable", evictions, uncached);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lts_pkg.sv
rtl/lts_store.sv
rtl/lts_cmp.sv
rtl/lru_tag_store_unit.sv
tb/tb_top.sv
